// File: rtl/ups_pkg.sv
// ---------------------------------------------------------------------------
// ups_pkg: shared definitions for the unimodal peak search unit
// Default widths, register reset value, search constants and phase codes.
// ---------------------------------------------------------------------------
package ups_pkg;

   localparam int POSITION_BITS_DEFAULT = 17;
   localparam int VALUE_BITS_DEFAULT    = 32;

   // domain_high after reset
   localparam int DOMAIN_HIGH_RESET = 100000;

   // ternary rounds stop once the bracket is this narrow; also the rescan reach
   localparam int SCAN_SPAN = 3;

   // request operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_REPLY = 1'b1;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_FIRST  = 6'b000010,
      PH_SECOND = 6'b000100,
      PH_SCAN   = 6'b001000,
      PH_RESCAN = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

endpackage

// File: rtl/ups_channels.sv
// ---------------------------------------------------------------------------
// ups_channels: request and response channels of the peak search unit
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ---------------------------------------------------------------------------
interface ups_req_if #(
   parameter int VALUE_BITS = ups_pkg::VALUE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [VALUE_BITS-1:0] measured_value;

   modport source (output valid, output operation, output measured_value, input ready);
   modport sink   (input valid, input operation, input measured_value, output ready);
endinterface

interface ups_rsp_if #(
   parameter int POSITION_BITS = ups_pkg::POSITION_BITS_DEFAULT
);
   logic                     valid;
   logic                     ready;
   logic                     query_valid;
   logic [POSITION_BITS-1:0] query_position;
   logic                     search_done;
   logic [POSITION_BITS-1:0] best_position;

   modport source (output valid, output query_valid, output query_position,
                   output search_done, output best_position, input ready);
   modport sink   (input valid, input query_valid, input query_position,
                   input search_done, input best_position, output ready);
endinterface

// File: rtl/unimodal_peak_search_unit.sv
// ---------------------------------------------------------------------------
// unimodal_peak_search_unit: probe sequencer for a unimodal peak search
// Integer ternary search over 0..domain_high followed by a linear scan and
// a local rescan; answers each request with the next probe or the result.
// ---------------------------------------------------------------------------
// Every request produces exactly one response, in the cycle after it is taken;
// a new request is accepted in every cycle as long as the response register
// is empty or being drained. The cycle time is set by one path: a subtract
// feeding the divide-by-three multiplier (POSITION_BITS x POSITION_BITS+2),
// which is used either for the opening probe or to precompute the next
// round's third while the first probe of a round is being answered.
// A start request (operation 0) abandons any search in progress. Write
// domain_high only while no request is outstanding; it is sampled at start.
module unimodal_peak_search_unit #(
   parameter int POSITION_BITS = ups_pkg::POSITION_BITS_DEFAULT,
   parameter int VALUE_BITS    = ups_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   ups_req_if.sink                  req,
   ups_rsp_if.source                rsp,
   input  logic                     csr_wr_en,
   input  logic [POSITION_BITS-1:0] csr_wr_data
);

   localparam int DIV_SHIFT = POSITION_BITS + 2;
   // ceil-ish reciprocal of 3; exact floor(x/3) for x below 2**POSITION_BITS
   localparam logic [DIV_SHIFT-1:0] DIV_MULT =
      DIV_SHIFT'(((64'd1 << DIV_SHIFT) / 64'd3) + 64'd1);
   localparam logic [POSITION_BITS-1:0] SPAN = POSITION_BITS'(ups_pkg::SCAN_SPAN);

   ups_pkg::phase_type phase_ff, phase_in;

   logic [POSITION_BITS-1:0] domain_high_ff;
   logic [POSITION_BITS-1:0] low_ff, low_in;
   logic [POSITION_BITS-1:0] high_ff, high_in;
   logic [POSITION_BITS-1:0] diff_ff, diff_in;
   logic [POSITION_BITS-1:0] third_ff, third_in;
   logic [POSITION_BITS-1:0] third_nx_ff, third_nx_in;
   logic [POSITION_BITS-1:0] probe_high_ff, probe_high_in;
   logic [VALUE_BITS-1:0]    first_value_ff, first_value_in;
   logic [VALUE_BITS-1:0]    best_value_ff, best_value_in;
   logic                     best_seen_ff, best_seen_in;
   logic [POSITION_BITS-1:0] best_spot_ff, best_spot_in;
   logic [POSITION_BITS-1:0] scan_index_ff, scan_index_in;
   logic [POSITION_BITS-1:0] scan_end_ff, scan_end_in;

   logic                     rsp_valid_ff;
   logic                     query_valid_ff, query_valid_in;
   logic [POSITION_BITS-1:0] query_position_ff, query_position_in;
   logic                     search_done_ff, search_done_in;
   logic [POSITION_BITS-1:0] best_position_ff, best_position_in;

   logic                     req_fire;
   logic [POSITION_BITS-1:0] div_operand;
   logic [POSITION_BITS+DIV_SHIFT-1:0] div_product;
   logic [POSITION_BITS-1:0] div_quotient;
   logic                     take_value;
   logic [POSITION_BITS-1:0] new_low, new_high, new_diff;
   logic [POSITION_BITS:0]   reach_high;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   // shared divide-by-three: opening third at start, next round's third otherwise
   assign div_operand  = (req.operation == ups_pkg::OP_START) ? domain_high_ff
                                                              : diff_ff - third_ff;
   assign div_product  = {{DIV_SHIFT{1'b0}}, div_operand}
                       * {{POSITION_BITS{1'b0}}, DIV_MULT};
   assign div_quotient = div_product[POSITION_BITS+DIV_SHIFT-1:DIV_SHIFT];

   // a scan sample wins on the first strict maximum
   assign take_value = !best_seen_ff || (req.measured_value > best_value_ff);

   assign new_low  = (first_value_ff < req.measured_value) ? low_ff + third_ff : low_ff;
   assign new_high = (first_value_ff < req.measured_value) ? high_ff : high_ff - third_ff;
   assign new_diff = diff_ff - third_ff;

   always_comb begin
      phase_in          = phase_ff;
      low_in            = low_ff;
      high_in           = high_ff;
      diff_in           = diff_ff;
      third_in          = third_ff;
      third_nx_in       = third_nx_ff;
      probe_high_in     = probe_high_ff;
      first_value_in    = first_value_ff;
      best_value_in     = best_value_ff;
      best_seen_in      = best_seen_ff;
      best_spot_in      = best_spot_ff;
      scan_index_in     = scan_index_ff;
      scan_end_in       = scan_end_ff;
      query_valid_in    = 1'b0;
      query_position_in = '0;
      search_done_in    = 1'b0;
      best_position_in  = '0;
      reach_high        = '0;

      if (req.operation == ups_pkg::OP_START) begin
         probe_high_in  = domain_high_ff;
         low_in         = '0;
         high_in        = domain_high_ff;
         diff_in        = domain_high_ff;
         third_in       = div_quotient;
         first_value_in = '0;
         best_seen_in   = 1'b0;
         best_spot_in   = '0;
         query_valid_in = 1'b1;
         if (domain_high_ff > SPAN) begin
            phase_in          = ups_pkg::PH_FIRST;
            query_position_in = div_quotient;
         end else begin
            phase_in          = ups_pkg::PH_SCAN;
            scan_index_in     = '0;
            scan_end_in       = domain_high_ff;
            query_position_in = '0;
         end
      end else begin
         case (phase_ff)
            ups_pkg::PH_FIRST: begin
               first_value_in    = req.measured_value;
               third_nx_in       = div_quotient;
               phase_in          = ups_pkg::PH_SECOND;
               query_valid_in    = 1'b1;
               query_position_in = high_ff - third_ff;
            end
            ups_pkg::PH_SECOND: begin
               low_in         = new_low;
               high_in        = new_high;
               diff_in        = new_diff;
               query_valid_in = 1'b1;
               if (new_diff > SPAN) begin
                  phase_in          = ups_pkg::PH_FIRST;
                  third_in          = third_nx_ff;
                  query_position_in = new_low + third_nx_ff;
               end else begin
                  phase_in          = ups_pkg::PH_SCAN;
                  scan_index_in     = new_low;
                  scan_end_in       = new_high;
                  best_seen_in      = 1'b0;
                  query_position_in = new_low;
               end
            end
            ups_pkg::PH_SCAN: begin
               if (take_value) begin
                  best_seen_in  = 1'b1;
                  best_value_in = req.measured_value;
                  best_spot_in  = scan_index_ff;
               end
               query_valid_in = 1'b1;
               if (scan_index_ff >= scan_end_ff) begin
                  // rescan a window around the best spot, clipped to the domain
                  reach_high    = {1'b0, best_spot_in} + {1'b0, SPAN};
                  scan_index_in = (best_spot_in >= SPAN) ? best_spot_in - SPAN : '0;
                  scan_end_in   = (reach_high <= {1'b0, probe_high_ff})
                                  ? reach_high[POSITION_BITS-1:0] : probe_high_ff;
                  phase_in      = ups_pkg::PH_RESCAN;
               end else begin
                  scan_index_in = scan_index_ff + 1'b1;
               end
               query_position_in = scan_index_in;
            end
            ups_pkg::PH_RESCAN: begin
               if (take_value) begin
                  best_seen_in  = 1'b1;
                  best_value_in = req.measured_value;
                  best_spot_in  = scan_index_ff;
               end
               if (scan_index_ff >= scan_end_ff) begin
                  phase_in         = ups_pkg::PH_DONE;
                  search_done_in   = 1'b1;
                  best_position_in = best_spot_in;
               end else begin
                  scan_index_in     = scan_index_ff + 1'b1;
                  query_valid_in    = 1'b1;
                  query_position_in = scan_index_in;
               end
            end
            ups_pkg::PH_DONE: begin
               search_done_in   = 1'b1;
               best_position_in = best_spot_ff;
            end
            default: begin
               // reply while idle: all-zero response
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         domain_high_ff <= POSITION_BITS'(ups_pkg::DOMAIN_HIGH_RESET);
      end else if (csr_wr_en) begin
         domain_high_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ups_pkg::PH_IDLE;
         best_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff     <= phase_in;
            best_seen_ff <= best_seen_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         low_ff            <= low_in;
         high_ff           <= high_in;
         diff_ff           <= diff_in;
         third_ff          <= third_in;
         third_nx_ff       <= third_nx_in;
         probe_high_ff     <= probe_high_in;
         first_value_ff    <= first_value_in;
         best_value_ff     <= best_value_in;
         best_spot_ff      <= best_spot_in;
         scan_index_ff     <= scan_index_in;
         scan_end_ff       <= scan_end_in;
         query_valid_ff    <= query_valid_in;
         query_position_ff <= query_position_in;
         search_done_ff    <= search_done_in;
         best_position_ff  <= best_position_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.query_valid    = query_valid_ff;
   assign rsp.query_position = query_position_ff;
   assign rsp.search_done    = search_done_ff;
   assign rsp.best_position  = best_position_ff;

`ifndef SYNTHESIS
   a_bracket_ordered: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ups_pkg::PH_FIRST || phase_ff == ups_pkg::PH_SECOND)
      |-> (low_ff <= high_ff && diff_ff == high_ff - low_ff))
      else $error("ternary bracket inconsistent");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ups_pkg::PH_SCAN || phase_ff == ups_pkg::PH_RESCAN)
      |-> (scan_index_ff <= scan_end_ff && scan_end_ff <= probe_high_ff))
      else $error("scan index outside window");

   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_query_or_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(query_valid_ff && search_done_ff))
      else $error("response both queries and reports done");
`endif

endmodule
